// ----- rtl/core/pdt_pkg.sv -----
`timescale 1ns / 1ps

package pdt_pkg;

	localparam int TASKS   = 8;
	localparam int IDX_W   = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam int MODE_W  = 3;
	localparam int SLOT_W  = 6;
	localparam int RANGE_W = SLOT_W + 1;
	localparam int PER_W   = 16;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = $clog2(PER_W);

	localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SUSPEND = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RESUME  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_REFUSED = 2'd1;
	localparam logic [STAT_W-1:0] ST_DUE     = 2'd2;
	localparam logic [STAT_W-1:0] ST_DONE    = 2'd3;

	typedef struct packed {
		logic done;
		logic zero;
	} rem_stat_t;

endpackage

// ----- rtl/core/pdt_rem_unit.sv -----
`timescale 1ns / 1ps

module pdt_rem_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pdt_pkg::PER_W-1:0]  dividend,
	input  logic [pdt_pkg::PER_W-1:0]  divisor,
	output pdt_pkg::rem_stat_t         stat
);

	logic [pdt_pkg::PER_W-1:0] rem_q;
	logic [pdt_pkg::PER_W-1:0] num_q;
	logic [pdt_pkg::PER_W-1:0] den_q;
	logic [pdt_pkg::CNT_W-1:0] cnt_q;
	logic                      run_q;
	logic                      done_q;
	logic [pdt_pkg::PER_W:0]   trial;
	logic [pdt_pkg::PER_W:0]   diff;
	logic                      fits;
	logic                      last_step;

	// one restoring step: bring down the next dividend bit, subtract if it fits
	assign trial     = {rem_q, num_q[pdt_pkg::PER_W-1]};
	assign diff      = trial - {1'b0, den_q};
	assign fits      = trial >= {1'b0, den_q};
	assign last_step = cnt_q == pdt_pkg::CNT_W'(pdt_pkg::PER_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && last_step;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
			den_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? diff[pdt_pkg::PER_W-1:0] : trial[pdt_pkg::PER_W-1:0];
			num_q <= {num_q[pdt_pkg::PER_W-2:0], 1'b0};
		end
	end

	assign stat.done = done_q;
	assign stat.zero = rem_q == '0;

endmodule

// ----- rtl/core/periodic_task_dispatcher.sv -----
`timescale 1ns / 1ps

// Priority-ordered table of TASKS periodic task slots with a wrapping 16-bit tick
// counter. Create, delete, suspend and resume answer with one item, as does any
// other mode, which is refused. A tick walks the slots from 0 upward: an empty,
// suspended or zero-period slot is skipped; any other slot runs a 16-step serial
// remainder of the tick count by its period and gets a due item if the remainder
// is zero. The closing item follows the walk. Input is taken only while no tick
// walk runs and the result register is free to take a new item.
module periodic_task_dispatcher (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pdt_pkg::MODE_W-1:0]  mode,
	input  logic [pdt_pkg::SLOT_W-1:0]  slot,
	input  logic [pdt_pkg::PER_W-1:0]   period,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pdt_pkg::STAT_W-1:0]  status,
	output logic [pdt_pkg::SLOT_W-1:0]  task_res,
	output logic                        last
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_DIV   = 5'b00100,
		S_EMIT  = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t                         state_q, state_d;
	logic [pdt_pkg::IDX_W-1:0]      idx_q, idx_d;
	logic [pdt_pkg::PER_W-1:0]      tick_q;
	logic [pdt_pkg::TASKS-1:0]      occ_q;
	logic [pdt_pkg::TASKS-1:0]      susp_q;
	logic [pdt_pkg::PER_W-1:0]      prd_q [pdt_pkg::TASKS];

	logic                           ovalid_q;
	logic [pdt_pkg::STAT_W-1:0]     ostat_q;
	logic [pdt_pkg::SLOT_W-1:0]     ores_q;
	logic                           olast_q;

	logic                           acc;
	logic                           out_free;
	logic                           is_tick;
	logic                           in_range;
	logic [pdt_pkg::IDX_W-1:0]      idx_in;
	logic [pdt_pkg::IDX_W-1:0]      rd_idx;
	logic                           occ_rd;
	logic                           susp_rd;
	logic [pdt_pkg::PER_W-1:0]      prd_rd;
	logic                           cmd_ok;
	logic                           due_cand;
	logic                           last_idx;
	logic                           rem_start;
	pdt_pkg::rem_stat_t             rem_stat;

	logic                           load_out;
	logic [pdt_pkg::STAT_W-1:0]     ld_stat;
	logic [pdt_pkg::SLOT_W-1:0]     ld_res;
	logic                           ld_last;

	assign out_free = !ovalid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign acc      = in_valid && in_ready;
	assign is_tick  = mode == pdt_pkg::MODE_TICK;
	assign in_range = {1'b0, slot} < pdt_pkg::RANGE_W'(pdt_pkg::TASKS);
	assign idx_in   = slot[pdt_pkg::IDX_W-1:0];

	// single table read port: the addressed slot when idle, the walk slot otherwise
	assign rd_idx  = (state_q == S_IDLE) ? idx_in : idx_q;
	assign occ_rd  = occ_q[rd_idx];
	assign susp_rd = susp_q[rd_idx];
	assign prd_rd  = prd_q[rd_idx];

	assign due_cand  = occ_rd && !susp_rd && (prd_rd != '0);
	assign last_idx  = idx_q == pdt_pkg::IDX_W'(pdt_pkg::TASKS - 1);
	assign rem_start = (state_q == S_CHECK) && due_cand;

	always_comb begin
		case (mode)
			pdt_pkg::MODE_CREATE:  cmd_ok = in_range && !occ_rd;
			pdt_pkg::MODE_DELETE,
			pdt_pkg::MODE_SUSPEND,
			pdt_pkg::MODE_RESUME:  cmd_ok = in_range;
			default:               cmd_ok = 1'b0;
		endcase
	end

	pdt_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (tick_q),
		.divisor  (prd_rd),
		.stat     (rem_stat)
	);

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		load_out = 1'b0;
		ld_stat  = pdt_pkg::ST_OK;
		ld_res   = '0;
		ld_last  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (is_tick) begin
						state_d = S_CHECK;
						idx_d   = '0;
					end else begin
						load_out = 1'b1;
						ld_stat  = cmd_ok ? pdt_pkg::ST_OK : pdt_pkg::ST_REFUSED;
						ld_res   = slot;
						ld_last  = 1'b1;
					end
				end
			end
			S_CHECK: begin
				if (due_cand) begin
					state_d = S_DIV;
				end else if (last_idx) begin
					state_d = S_FIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_DIV: begin
				if (rem_stat.done) begin
					if (rem_stat.zero) begin
						state_d = S_EMIT;
					end else if (last_idx) begin
						state_d = S_FIN;
					end else begin
						state_d = S_CHECK;
						idx_d   = idx_q + 1'b1;
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					ld_stat  = pdt_pkg::ST_DUE;
					ld_res   = pdt_pkg::SLOT_W'(idx_q);
					if (last_idx) begin
						state_d = S_FIN;
					end else begin
						state_d = S_CHECK;
						idx_d   = idx_q + 1'b1;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					load_out = 1'b1;
					ld_stat  = pdt_pkg::ST_DONE;
					ld_last  = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			tick_q   <= '0;
			occ_q    <= '0;
			susp_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (acc && is_tick) begin
				tick_q <= tick_q + 1'b1;
			end
			if (acc && !is_tick && cmd_ok) begin
				case (mode)
					pdt_pkg::MODE_CREATE:  occ_q[idx_in]  <= 1'b1;
					pdt_pkg::MODE_DELETE:  occ_q[idx_in]  <= 1'b0;
					pdt_pkg::MODE_SUSPEND: susp_q[idx_in] <= 1'b1;
					pdt_pkg::MODE_RESUME:  susp_q[idx_in] <= 1'b0;
					default:               ;
				endcase
			end
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && cmd_ok && (mode == pdt_pkg::MODE_CREATE)) begin
			prd_q[idx_in] <= period;
		end
		if (load_out) begin
			ostat_q <= ld_stat;
			ores_q  <= ld_res;
			olast_q <= ld_last;
		end
	end

	assign out_valid = ovalid_q;
	assign status    = ostat_q;
	assign task_res  = ores_q;
	assign last      = olast_q;

`ifndef SYNTHESIS
	a_tick_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_tick) |=> (state_q == S_CHECK && idx_q == '0))
		else $error("tick walk did not start at slot zero");

	a_rem_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_stat.done |-> (state_q == S_DIV))
		else $error("remainder finished outside its wait state");

	a_emit_nonzero_period: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (prd_rd != '0 && occ_rd && !susp_rd))
		else $error("due item for a slot that cannot fire");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == pdt_pkg::ST_DONE) |-> (last && task_res == '0))
		else $error("closing item malformed");

	a_no_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("result item overwritten before it was taken");
`endif

endmodule

// ----- tb/dispatch_checker.sv -----
`timescale 1ns / 1ps

module dispatch_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [pdt_pkg::MODE_W-1:0] mode,
	input  logic [pdt_pkg::SLOT_W-1:0] slot,
	input  logic [pdt_pkg::PER_W-1:0]  period,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [pdt_pkg::STAT_W-1:0] status,
	input  logic [pdt_pkg::SLOT_W-1:0] task_res,
	input  logic                       last,
	output int                         errors,
	output int                         pending
);

	typedef struct packed {
		logic [pdt_pkg::STAT_W-1:0] status;
		logic [pdt_pkg::SLOT_W-1:0] task_res;
		logic                       last;
	} answer_t;

	logic                      occ_tab [pdt_pkg::TASKS];
	logic                      sus_tab [pdt_pkg::TASKS];
	logic [pdt_pkg::PER_W-1:0] per_tab [pdt_pkg::TASKS];
	logic [pdt_pkg::PER_W-1:0] ticks;
	answer_t                   answers [$];
	answer_t                   want;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// Work out the answers that one event causes and queue them in order.
	task automatic dispatch_event(input logic [pdt_pkg::MODE_W-1:0] m,
			input logic [pdt_pkg::SLOT_W-1:0] s, input logic [pdt_pkg::PER_W-1:0] p);
		int idx;
		idx = s;
		if (m == pdt_pkg::MODE_TICK) begin
			ticks = ticks + 1'b1;
			for (int i = 0; i < pdt_pkg::TASKS; i++) begin
				if (occ_tab[i] && !sus_tab[i] && per_tab[i] != '0 &&
						(ticks % per_tab[i]) == '0)
					answers.push_back(answer_t'{pdt_pkg::ST_DUE, pdt_pkg::SLOT_W'(i), 1'b0});
			end
			answers.push_back(answer_t'{pdt_pkg::ST_DONE, '0, 1'b1});
		end else if (m > pdt_pkg::MODE_RESUME || idx >= pdt_pkg::TASKS) begin
			answers.push_back(answer_t'{pdt_pkg::ST_REFUSED, s, 1'b1});
		end else if (m == pdt_pkg::MODE_CREATE && occ_tab[idx]) begin
			answers.push_back(answer_t'{pdt_pkg::ST_REFUSED, s, 1'b1});
		end else begin
			case (m)
				pdt_pkg::MODE_CREATE: begin
					per_tab[idx] = p;
					occ_tab[idx] = 1'b1;
				end
				pdt_pkg::MODE_DELETE:  occ_tab[idx] = 1'b0;
				pdt_pkg::MODE_SUSPEND: sus_tab[idx] = 1'b1;
				default:               sus_tab[idx] = 1'b0;
			endcase
			answers.push_back(answer_t'{pdt_pkg::ST_OK, s, 1'b1});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pdt_pkg::TASKS; i++) begin
				occ_tab[i] = 1'b0;
				sus_tab[i] = 1'b0;
				per_tab[i] = '0;
			end
			ticks = '0;
			answers.delete();
			errors = 0;
			pending = 0;
		end else begin
			// A result can never stem from the item taken at the same edge: check first.
			if (out_valid && out_ready) begin
				if (answers.size() == 0) begin
					report_mismatch($sformatf("unexpected result status %0d task_res %0d last %0d",
						status, task_res, last));
				end else begin
					want = answers.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
					if (task_res !== want.task_res)
						report_mismatch($sformatf("task_res %0d, expected %0d", task_res,
							want.task_res));
					if (last !== want.last)
						report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
				end
			end
			if (in_valid && in_ready)
				dispatch_event(mode, slot, period);
			pending = answers.size();
		end
	end

endmodule

// ----- tb/periodic_task_dispatcher_tb.sv -----
`timescale 1ns / 1ps

module periodic_task_dispatcher_tb;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [pdt_pkg::MODE_W-1:0] mode;
	logic [pdt_pkg::SLOT_W-1:0] slot;
	logic [pdt_pkg::PER_W-1:0]  period;
	logic                       out_valid;
	logic                       out_ready;
	logic [pdt_pkg::STAT_W-1:0] status;
	logic [pdt_pkg::SLOT_W-1:0] task_res;
	logic                       last;

	int errors;
	int pending;
	int snd_idle;
	int rcv_idle;
	int hold_cycles;

	periodic_task_dispatcher u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.slot     (slot),
		.period   (period),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.task_res (task_res),
		.last     (last)
	);

	dispatch_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.slot     (slot),
		.period   (period),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.task_res (task_res),
		.last     (last),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: random back-pressure, with a long hold-off on request.
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			out_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	// Entered and left at a falling edge.
	task automatic send_event(input logic [pdt_pkg::MODE_W-1:0] m,
			input logic [pdt_pkg::SLOT_W-1:0] s, input logic [pdt_pkg::PER_W-1:0] p);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		slot     <= s;
		period   <= p;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic random_event();
		int                         pick;
		int                         sel;
		logic [pdt_pkg::SLOT_W-1:0] s;
		logic [pdt_pkg::PER_W-1:0]  p;
		logic [pdt_pkg::MODE_W-1:0] m;
		pick = $urandom_range(99);
		sel  = $urandom_range(9);
		s = ($urandom_range(9) == 0) ? pdt_pkg::SLOT_W'($urandom_range(63)) :
			pdt_pkg::SLOT_W'($urandom_range(pdt_pkg::TASKS - 1));
		// Keep most periods short so that tasks fall due often.
		if (sel <= 5)
			p = pdt_pkg::PER_W'($urandom_range(1, 6));
		else if (sel == 6)
			p = '0;
		else if (sel == 7)
			p = '1;
		else
			p = pdt_pkg::PER_W'($urandom);
		if (pick < 40)
			m = pdt_pkg::MODE_TICK;
		else if (pick < 62)
			m = pdt_pkg::MODE_CREATE;
		else if (pick < 72)
			m = pdt_pkg::MODE_DELETE;
		else if (pick < 82)
			m = pdt_pkg::MODE_SUSPEND;
		else if (pick < 92)
			m = pdt_pkg::MODE_RESUME;
		else
			m = pdt_pkg::MODE_W'($urandom_range(pdt_pkg::MODE_RESUME + 1,
				2**pdt_pkg::MODE_W - 1));
		send_event(m, s, p);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		mode        = pdt_pkg::MODE_TICK;
		slot        = '0;
		period      = '0;
		snd_idle    = 0;
		rcv_idle    = 0;
		hold_cycles = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		snd_idle = 34;
		rcv_idle = 49;
		send_event(pdt_pkg::MODE_TICK, '0, '0);
		send_event(pdt_pkg::MODE_CREATE, '0, pdt_pkg::PER_W'(1));
		send_event(pdt_pkg::MODE_CREATE, pdt_pkg::SLOT_W'(pdt_pkg::TASKS - 1), '1);
		send_event(pdt_pkg::MODE_CREATE, pdt_pkg::SLOT_W'(3), '0);
		send_event(pdt_pkg::MODE_CREATE, pdt_pkg::SLOT_W'(2), pdt_pkg::PER_W'(2));
		send_event(pdt_pkg::MODE_CREATE, '0, pdt_pkg::PER_W'(5));
		send_event(pdt_pkg::MODE_CREATE, '1, pdt_pkg::PER_W'(1));
		send_event(pdt_pkg::MODE_SUSPEND, pdt_pkg::SLOT_W'(pdt_pkg::TASKS), '0);
		send_event(pdt_pkg::MODE_TICK, '1, '1);
		send_event(pdt_pkg::MODE_SUSPEND, pdt_pkg::SLOT_W'(2), '0);
		send_event(pdt_pkg::MODE_TICK, '0, '0);
		send_event(pdt_pkg::MODE_RESUME, pdt_pkg::SLOT_W'(2), '0);
		send_event(pdt_pkg::MODE_DELETE, pdt_pkg::SLOT_W'(pdt_pkg::TASKS - 1), '0);
		send_event(pdt_pkg::MODE_DELETE, pdt_pkg::SLOT_W'(pdt_pkg::TASKS - 1), '0);
		// A free slot keeps its suspended bit through a create.
		send_event(pdt_pkg::MODE_SUSPEND, pdt_pkg::SLOT_W'(5), '0);
		send_event(pdt_pkg::MODE_CREATE, pdt_pkg::SLOT_W'(5), pdt_pkg::PER_W'(1));
		send_event(pdt_pkg::MODE_TICK, '0, '0);
		send_event(pdt_pkg::MODE_RESUME, pdt_pkg::SLOT_W'(5), '0);
		for (int m = pdt_pkg::MODE_RESUME + 1; m < 2**pdt_pkg::MODE_W; m++)
			send_event(pdt_pkg::MODE_W'(m), pdt_pkg::SLOT_W'(1), '1);
		send_event(pdt_pkg::MODE_DELETE, pdt_pkg::SLOT_W'(3), '0);
		for (int i = 1; i < pdt_pkg::TASKS; i++) begin
			if (i != 2 && i != 5)
				send_event(pdt_pkg::MODE_CREATE, pdt_pkg::SLOT_W'(i), pdt_pkg::PER_W'(1));
		end
		send_event(pdt_pkg::MODE_TICK, '0, '0);
		// Count reaches six: every slot is due.
		send_event(pdt_pkg::MODE_TICK, '0, '0);
		wait_drained();

		// Stall the output long enough for the block to stop taking items.
		hold_cycles = 400;
		repeat (50) random_event();
		wait_drained();

		snd_idle = 49;
		rcv_idle = 34;
		repeat (25) random_event();
		wait_drained();
		repeat (25) random_event();
		wait_drained();

		snd_idle = 0;
		rcv_idle = 0;
		repeat (25) random_event();
		wait_drained();

		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
